/* rtl/fccm_pkg.sv */
// Shared types and constants for the cluster chain manager.
// Holds command codes, status codes and controller states; depends on nothing.
`timescale 1ns / 1ps

package fccm_pkg;

	// Default number of link entries in the table.
	localparam int MAX_CLUSTERS_DEF = 1024;

	// Reset value of the cluster_count register.
	localparam logic [10:0] CLUSTER_COUNT_RESET = 11'd761;

	// Link entry encodings.
	localparam logic [15:0] END_OF_CHAIN = 16'hFFFF;
	localparam logic [15:0] FREE_ENTRY   = 16'h0000;

	// Response status codes.
	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_NO_FREE    = 2'd1;
	localparam logic [1:0] STATUS_WALK_LIMIT = 2'd2;

	// Request command codes.
	typedef enum logic [2:0] {
		OP_CLEAR = 3'd0,
		OP_ALLOC = 3'd1,
		OP_FREE  = 3'd2,
		OP_READ  = 3'd3,
		OP_WRITE = 3'd4
	} op_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ALLOC,
		S_ALLOC_END,
		S_WALK,
		S_READ,
		S_RESP
	} state_t;

endpackage

/* rtl/fat_cluster_chain_manager.sv */
// Cluster chain manager: link table memory, command controller and APB register.
// Depends on fccm_pkg for codes, states and defaults.
`timescale 1ns / 1ps

// The block keeps a table of MAX_CLUSTERS 16-bit link entries in one synchronous
// memory (one write and one read port, registered read data). A value of 0
// marks a free cluster, 0xFFFF the end of a chain, anything else the next cluster.
// One request is handled at a time, and each request produces exactly one response.
// After reset the block sweeps the table to zero, one entry per cycle, and holds
// req_stall high while it does so; APB writes are taken all the while.
// Request handling: a clear request repeats the same sweep; allocate scans from
// cluster 0 upward reading one entry per cycle, stopping when enough clusters
// are taken or at the scan limit when the table runs out; free chain walks one
// link per cycle, at most MAX_CLUSTERS steps.
// A new request is taken while the previous response still waits on rsp_stall.
// The cluster_count register (APB byte address 0) bounds the free search.
module fat_cluster_chain_manager #(
	parameter int MAX_CLUSTERS = fccm_pkg::MAX_CLUSTERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	// Request channel.
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  op,
	input  logic [9:0]  cluster,
	input  logic [15:0] value,
	input  logic [7:0]  count,

	// Response channel.
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [15:0] result,
	output logic [1:0]  status,

	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Address width of the table, and width of counters that can hold the depth.
	localparam int AW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int CW = $clog2(MAX_CLUSTERS + 1);
	localparam logic [16:0] MAX_W  = 17'(MAX_CLUSTERS);
	localparam logic [AW-1:0] LAST_ENTRY = AW'(MAX_CLUSTERS - 1);
	localparam logic [CW-1:0] LAST_STEP  = CW'(MAX_CLUSTERS - 1);
	localparam logic [CW-1:0] DEPTH_C    = CW'(MAX_CLUSTERS);

	// Configuration register.
	logic [10:0] cluster_count_q;
	logic        cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready && !paddr[2];
	assign prdata    = paddr[2] ? 32'd0 : 32'(cluster_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_count_q <= fccm_pkg::CLUSTER_COUNT_RESET;
		end else if (cfg_write) begin
			cluster_count_q <= pwdata[10:0];
		end
	end

	// Link table memory and its read pipeline stage.
	logic [15:0]   link_mem [MAX_CLUSTERS];
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [15:0]   mem_wd;
	logic          mem_re;
	logic [AW-1:0] mem_ra;
	logic [15:0]   rdata_s1;
	logic [AW-1:0] addr_s1;
	logic          fwd_s1;
	logic          rvalid_s1;
	logic [15:0]   rd_eff;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_s1 <= link_mem[mem_ra];
		end
		addr_s1 <= mem_ra;
		fwd_s1  <= mem_we && (mem_wa == mem_ra);
	end

	// A read that meets a write to the same entry in one cycle sees the new value.
	// The only such write is the walk's freeing write, so the value is zero.
	assign rd_eff = fwd_s1 ? fccm_pkg::FREE_ENTRY : rdata_s1;

	// Controller state.
	fccm_pkg::state_t state_q, state_d;
	logic [AW-1:0] sweep_q, sweep_d;
	logic          clr_resp_q, clr_resp_d;
	logic [CW-1:0] scan_q, scan_d;
	logic [7:0]    remaining_q, remaining_d;
	logic [AW-1:0] prev_q, prev_d;
	logic [AW-1:0] first_q, first_d;
	logic          taken_q, taken_d;
	logic [CW-1:0] steps_q, steps_d;
	logic [15:0]   res_q, res_d;
	logic [1:0]    stat_q, stat_d;
	logic          rsp_valid_q, rsp_valid_d;
	logic [15:0]   result_q, result_d;
	logic [1:0]    status_q, status_d;

	logic          accept;
	logic          rsp_free;
	logic [CW-1:0] lim;
	logic          cl_in_range;
	logic [16:0]   cl_w;
	logic          scan_issue;

	assign req_stall = (state_q != fccm_pkg::S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign result    = result_q;
	assign status    = status_q;

	// The free search never runs past the end of the table.
	assign lim = (17'(cluster_count_q) > MAX_W) ? DEPTH_C : CW'(cluster_count_q);

	assign cl_w        = 17'(cluster);
	assign cl_in_range = (cl_w < MAX_W);
	assign scan_issue  = (scan_q < lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fccm_pkg::S_CLEAR;
			sweep_q     <= '0;
			clr_resp_q  <= 1'b0;
			taken_q     <= 1'b0;
			rvalid_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			sweep_q     <= sweep_d;
			clr_resp_q  <= clr_resp_d;
			taken_q     <= taken_d;
			rvalid_s1   <= mem_re;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		scan_q      <= scan_d;
		remaining_q <= remaining_d;
		prev_q      <= prev_d;
		first_q     <= first_d;
		steps_q     <= steps_d;
		res_q       <= res_d;
		stat_q      <= stat_d;
		result_q    <= result_d;
		status_q    <= status_d;
	end

	always_comb begin
		state_d     = state_q;
		sweep_d     = sweep_q;
		clr_resp_d  = clr_resp_q;
		scan_d      = scan_q;
		remaining_d = remaining_q;
		prev_d      = prev_q;
		first_d     = first_q;
		taken_d     = taken_q;
		steps_d     = steps_q;
		res_d       = res_q;
		stat_d      = stat_q;
		result_d    = result_q;
		status_d    = status_q;
		rsp_valid_d = rsp_valid_q && rsp_stall;
		mem_we      = 1'b0;
		mem_wa      = prev_q;
		mem_wd      = fccm_pkg::FREE_ENTRY;
		mem_re      = 1'b0;
		mem_ra      = scan_q[AW-1:0];

		unique case (state_q)
			fccm_pkg::S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = sweep_q;
				mem_wd = fccm_pkg::FREE_ENTRY;
				if (sweep_q == LAST_ENTRY) begin
					state_d = clr_resp_q ? fccm_pkg::S_RESP : fccm_pkg::S_IDLE;
				end else begin
					sweep_d = sweep_q + 1'b1;
				end
			end

			fccm_pkg::S_IDLE: begin
				if (accept) begin
					res_d  = 16'd0;
					stat_d = fccm_pkg::STATUS_OK;
					unique case (op)
						fccm_pkg::OP_CLEAR: begin
							sweep_d    = '0;
							clr_resp_d = 1'b1;
							state_d    = fccm_pkg::S_CLEAR;
						end
						fccm_pkg::OP_ALLOC: begin
							if (count == 8'd0) begin
								res_d   = fccm_pkg::END_OF_CHAIN;
								state_d = fccm_pkg::S_RESP;
							end else begin
								remaining_d = count;
								scan_d      = '0;
								taken_d     = 1'b0;
								state_d     = fccm_pkg::S_ALLOC;
							end
						end
						fccm_pkg::OP_FREE: begin
							if (cl_in_range) begin
								mem_re  = 1'b1;
								mem_ra  = cl_w[AW-1:0];
								steps_d = '0;
								state_d = fccm_pkg::S_WALK;
							end else begin
								stat_d  = fccm_pkg::STATUS_WALK_LIMIT;
								state_d = fccm_pkg::S_RESP;
							end
						end
						fccm_pkg::OP_READ: begin
							if (cl_in_range) begin
								mem_re  = 1'b1;
								mem_ra  = cl_w[AW-1:0];
								state_d = fccm_pkg::S_READ;
							end else begin
								state_d = fccm_pkg::S_RESP;
							end
						end
						fccm_pkg::OP_WRITE: begin
							mem_we  = cl_in_range;
							mem_wa  = cl_w[AW-1:0];
							mem_wd  = value;
							state_d = fccm_pkg::S_RESP;
						end
						default: begin
							state_d = fccm_pkg::S_RESP;
						end
					endcase
				end
			end

			fccm_pkg::S_ALLOC: begin
				// Entries below the scan point are all taken, so one pass upward
				// finds every free cluster in order. Each find links the previous
				// one to it; the end mark goes on the last one when the scan stops.
				if (scan_issue) begin
					mem_re = 1'b1;
					mem_ra = scan_q[AW-1:0];
					scan_d = scan_q + 1'b1;
				end
				if (rvalid_s1 && (rd_eff == fccm_pkg::FREE_ENTRY)) begin
					if (taken_q) begin
						mem_we = 1'b1;
						mem_wa = prev_q;
						mem_wd = 16'(addr_s1);
					end else begin
						first_d = addr_s1;
					end
					prev_d      = addr_s1;
					taken_d     = 1'b1;
					remaining_d = remaining_q - 1'b1;
					if (remaining_q == 8'd1) begin
						res_d   = taken_q ? 16'(first_q) : 16'(addr_s1);
						stat_d  = fccm_pkg::STATUS_OK;
						state_d = fccm_pkg::S_ALLOC_END;
					end
				end else if (!scan_issue && !rvalid_s1) begin
					// Table ran out; whatever was taken stays linked.
					res_d   = fccm_pkg::END_OF_CHAIN;
					stat_d  = fccm_pkg::STATUS_NO_FREE;
					state_d = taken_q ? fccm_pkg::S_ALLOC_END : fccm_pkg::S_RESP;
				end
			end

			fccm_pkg::S_ALLOC_END: begin
				mem_we  = 1'b1;
				mem_wa  = prev_q;
				mem_wd  = fccm_pkg::END_OF_CHAIN;
				state_d = fccm_pkg::S_RESP;
			end

			fccm_pkg::S_WALK: begin
				// Free the entry just read and fetch the next link in the same cycle.
				if (rvalid_s1) begin
					mem_we  = 1'b1;
					mem_wa  = addr_s1;
					mem_wd  = fccm_pkg::FREE_ENTRY;
					steps_d = steps_q + 1'b1;
					if (rd_eff == fccm_pkg::END_OF_CHAIN) begin
						state_d = fccm_pkg::S_RESP;
					end else if (steps_q == LAST_STEP || 17'(rd_eff) >= MAX_W) begin
						stat_d  = fccm_pkg::STATUS_WALK_LIMIT;
						state_d = fccm_pkg::S_RESP;
					end else begin
						mem_re = 1'b1;
						mem_ra = rd_eff[AW-1:0];
					end
				end
			end

			fccm_pkg::S_READ: begin
				if (rvalid_s1) begin
					res_d   = rd_eff;
					state_d = fccm_pkg::S_RESP;
				end
			end

			fccm_pkg::S_RESP: begin
				if (rsp_free) begin
					result_d    = res_q;
					status_d    = stat_q;
					rsp_valid_d = 1'b1;
					clr_resp_d  = 1'b0;
					state_d     = fccm_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = fccm_pkg::S_IDLE;
			end
		endcase
	end

endmodule
